[src/gtm_pkg.sv]
// Shared widths, constants and types for the grouped trimmed mean block.
package gtm_pkg;

  // Samples per group and the sample width.
  localparam int GroupSize = 5;
  localparam int SampleW   = 16;

  // Count must hold GroupSize itself; the sum holds GroupSize full-scale samples.
  localparam int CountW = $clog2(GroupSize + 1);
  localparam int SumW   = SampleW + $clog2(GroupSize);

  // Divide by the kept entry count through a reciprocal multiply.
  // With Shift = SumW + ceil(log2(Div)) the rounded-up reciprocal gives an
  // exact floor for every SumW-bit dividend.
  localparam int Div    = GroupSize - 2;
  localparam int Shift  = SumW + $clog2(Div);
  localparam longint Recip = ((longint'(1) << Shift) + Div - 1) / Div;
  localparam int RecipW = $clog2(Recip + 1);
  localparam int ProdW  = SumW + RecipW;

  // Result word handed from the group accumulator to the output register.
  typedef struct packed {
    logic [SampleW-1:0] average;
    logic               updated;
  } result_t;

endpackage

[src/gtm_if.sv]
// Handshake channels for the sample input and the result output.
interface gtm_sample_if;
  logic                          valid;
  logic                          ready;
  logic [gtm_pkg::SampleW-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gtm_result_if;
  logic                          valid;
  logic                          ready;
  logic [gtm_pkg::SampleW-1:0]   average;
  logic                          updated;

  modport source (output valid, output average, output updated, input ready);
  modport sink   (input valid, input average, input updated, output ready);
endinterface

[src/gtm_accum.sv]
// Group accumulator: count, running sum, extremes and the held trimmed mean.
module gtm_accum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [gtm_pkg::SampleW-1:0] sample_i,
  output gtm_pkg::result_t            result_o
);

  logic [gtm_pkg::CountW-1:0]  count_q, count_d;
  logic [gtm_pkg::SumW-1:0]    sum_q, sum_d;
  logic [gtm_pkg::SampleW-1:0] largest_q, largest_d;
  logic [gtm_pkg::SampleW-1:0] smallest_q, smallest_d;
  logic [gtm_pkg::SampleW-1:0] held_q, held_d;

  logic                        group_full;
  logic                        group_first;
  logic [gtm_pkg::SumW-1:0]    kept_sum;
  logic [gtm_pkg::ProdW-1:0]   kept_prod;
  logic [gtm_pkg::SampleW-1:0] trimmed_avg;
  logic [gtm_pkg::SumW-1:0]    sum_base;

  // A full group closes when the next sample arrives.
  assign group_full  = (count_q == gtm_pkg::CountW'(gtm_pkg::GroupSize));
  assign group_first = group_full || (count_q == '0);

  // Drop one largest and one smallest, then divide by the kept count.
  assign kept_sum    = sum_q - gtm_pkg::SumW'(largest_q) - gtm_pkg::SumW'(smallest_q);
  assign kept_prod   = gtm_pkg::ProdW'(kept_sum) *
                       gtm_pkg::ProdW'(gtm_pkg::Recip[gtm_pkg::RecipW-1:0]);
  assign trimmed_avg = kept_prod[gtm_pkg::Shift +: gtm_pkg::SampleW];

  // Next state for one accepted sample.
  always_comb begin
    sum_base   = group_full ? '0 : sum_q;
    held_d     = group_full ? trimmed_avg : held_q;
    sum_d      = sum_base + gtm_pkg::SumW'(sample_i);
    count_d    = group_full ? gtm_pkg::CountW'(1) : count_q + gtm_pkg::CountW'(1);
    largest_d  = largest_q;
    smallest_d = smallest_q;
    if (group_first) begin
      largest_d  = sample_i;
      smallest_d = sample_i;
    end else begin
      if (sample_i > largest_q) begin
        largest_d = sample_i;
      end
      if (sample_i < smallest_q) begin
        smallest_d = sample_i;
      end
    end
  end

  // The result reflects the held average after this sample.
  assign result_o.average = held_d;
  assign result_o.updated = group_full;

  // State registers advance once per accepted sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      sum_q      <= '0;
      largest_q  <= '0;
      smallest_q <= '0;
      held_q     <= '0;
    end else if (step_i) begin
      count_q    <= count_d;
      sum_q      <= sum_d;
      largest_q  <= largest_d;
      smallest_q <= smallest_d;
      held_q     <= held_d;
    end
  end

endmodule

[src/grouped_trimmed_mean.sv]
// Top level of the grouped trimmed mean: input register, accumulator, result register.
//
//   channel  direction  payload                      word accepted when
//   in_i     in         sample[15:0]                 valid && ready
//   out_o    out        average[15:0], updated       valid && ready
//
// One word in gives one word out; a new word is taken every cycle while the output is not stalled.
// Each word passes through the input register, then the result register.
// The accumulator advances when the input register holds a word and the
// result register is empty or being drained in the same cycle.
// Reset clears the group count, sum, extremes and the held average to zero.
// A stall on the output holds the result register; in_i.ready drops once the
// input register also holds a word.
module grouped_trimmed_mean (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gtm_sample_if.sink           in_i,
  gtm_result_if.source         out_o
);

  logic                        in_valid_q;
  logic [gtm_pkg::SampleW-1:0] in_sample_q;
  logic                        out_valid_q;
  gtm_pkg::result_t            out_data_q;
  gtm_pkg::result_t            result;
  logic                        step;

  // The held word moves on when the result register can take it.
  assign step       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step;

  gtm_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (in_sample_q),
    .result_o (result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_sample_q <= in_i.sample;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.average = out_data_q.average;
  assign out_o.updated = out_data_q.updated;

endmodule

[sim/gtm_checker.sv]
// Checker for the grouped trimmed mean: predicts each result word and compares it.
`timescale 1ns / 100ps

module gtm_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [gtm_pkg::SampleW-1:0] sample_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [gtm_pkg::SampleW-1:0] average_i,
  input  logic                        updated_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          samples_o,
  output int                          updates_o,
  output int                          checked_o
);

  // Predicted group state, mirroring what the block holds.
  logic [gtm_pkg::CountW-1:0]  grp_count;
  logic [gtm_pkg::SumW-1:0]    grp_sum;
  logic [gtm_pkg::SampleW-1:0] grp_max;
  logic [gtm_pkg::SampleW-1:0] grp_min;
  logic [gtm_pkg::SampleW-1:0] avg_held;

  // Result words still owed by the block, oldest first.
  gtm_pkg::result_t owed_averages[$];

  // Advance the predicted group by one sample and return the word it produces.
  function automatic gtm_pkg::result_t trimmed_mean_step(
    input logic [gtm_pkg::SampleW-1:0] s
  );
    gtm_pkg::result_t         r;
    logic [gtm_pkg::SumW-1:0] kept;
    r.updated = 1'b0;
    // A full group is closed first: drop one largest and one smallest entry.
    if (grp_count >= gtm_pkg::CountW'(gtm_pkg::GroupSize)) begin
      kept      = grp_sum - gtm_pkg::SumW'(grp_max) - gtm_pkg::SumW'(grp_min);
      avg_held  = gtm_pkg::SampleW'(kept / gtm_pkg::SumW'(gtm_pkg::GroupSize - 2));
      r.updated = 1'b1;
      grp_count = '0;
      grp_sum   = '0;
    end
    // The first sample of a group sets both extremes.
    if (grp_count == '0) begin
      grp_max = s;
      grp_min = s;
    end else begin
      if (s > grp_max) grp_max = s;
      if (s < grp_min) grp_min = s;
    end
    grp_sum   = grp_sum + gtm_pkg::SumW'(s);
    grp_count = grp_count + gtm_pkg::CountW'(1);
    r.average = avg_held;
    return r;
  endfunction

  // Watch both channels; a sample word queues a prediction, a result word retires one.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    gtm_pkg::result_t want;
    if (!rst_ni) begin
      grp_count = '0;
      grp_sum   = '0;
      grp_max   = '0;
      grp_min   = '0;
      avg_held  = '0;
      owed_averages.delete();
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        owed_averages.insert(owed_averages.size(), trimmed_mean_step(sample_i));
        samples_o = samples_o + 1;
      end
      if (out_valid_i && out_ready_i) begin
        if (owed_averages.size() == 0) begin
          $error("unexpected result word: average %0d updated %0d", average_i, updated_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = owed_averages.pop_front();
          checked_o = checked_o + 1;
          if (updated_i) updates_o = updates_o + 1;
          if (average_i !== want.average) begin
            $error("average mismatch: expected %0d, got %0d", want.average, average_i);
            fail_count_o = fail_count_o + 1;
          end
          if (updated_i !== want.updated) begin
            $error("updated mismatch: expected %0d, got %0d", want.updated, updated_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      pending_o = owed_averages.size();
    end
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the grouped trimmed mean: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int RandPerPhase = 186;
  localparam int CycleLimit   = 500000;

  logic clk_i = 1'b0;
  logic rst_ni;

  gtm_sample_if smp_if ();
  gtm_result_if res_if ();

  int fail_count;
  int pending;
  int samples_seen;
  int updates_seen;
  int words_checked;
  int cycles;
  int src_idle_pct;
  int sink_stall_pct;
  logic [gtm_pkg::SampleW-1:0] last_sample;

  grouped_trimmed_mean dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp_if),
    .out_o  (res_if)
  );

  gtm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (smp_if.valid),
    .in_ready_i   (smp_if.ready),
    .sample_i     (smp_if.sample),
    .out_valid_i  (res_if.valid),
    .out_ready_i  (res_if.ready),
    .average_i    (res_if.average),
    .updated_i    (res_if.updated),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .samples_o    (samples_seen),
    .updates_o    (updates_seen),
    .checked_o    (words_checked)
  );

  // 8 ns clock.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Receiver side: stall at random according to the current phase.
  initial res_if.ready = 1'b0;
  always @(negedge clk_i) begin
    res_if.ready <= (sink_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles with %0d words outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Offer one sample word after a random idle gap and hold it until accepted.
  task automatic offer_sample(input logic [gtm_pkg::SampleW-1:0] v);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= v;
    last_sample = v;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Draw a sample: half uniform, the rest small, large, repeated, all-zero or all-one, or single-bit values.
  function automatic logic [gtm_pkg::SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      5:       return gtm_pkg::SampleW'($urandom_range(15));
      6:       return gtm_pkg::SampleW'($urandom_range(65535, 65520));
      7:       return last_sample;
      8:       return $urandom_range(1) ? '1 : '0;
      9:       return gtm_pkg::SampleW'(1) << $urandom_range(gtm_pkg::SampleW - 1);
      default: return gtm_pkg::SampleW'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [gtm_pkg::SampleW-1:0] directed[$];
    int phase_src[4];
    int phase_sink[4];
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    last_sample    = '0;
    smp_if.valid   = 1'b0;
    smp_if.sample  = '0;
    rst_ni         = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed groups: all full scale (sum needs full width), all zero (equal values),
    // extremes spread, a repeated minimum, mixed bit patterns, then one word to close.
    directed = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003,
                 16'h0007, 16'h0007, 16'h0007, 16'h0064, 16'h0007,
                 16'hFFFF, 16'h0000, 16'h8000, 16'h5555, 16'hAAAA,
                 16'h1234};
    foreach (directed[i]) offer_sample(directed[i]);

    // Random phases: no idling, sender idle, receiver stalling, both.
    phase_src  = '{0, 81, 0, 35};
    phase_sink = '{0, 0, 81, 35};
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = phase_src[p];
      sink_stall_pct = phase_sink[p];
      repeat (RandPerPhase) offer_sample(pick_sample());
    end
    smp_if.valid <= 1'b0;

    // Drain until no result word is still owed, then idle before the verdict.
    sink_stall_pct = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Covered %0d samples, %0d result words compared, %0d group averages refreshed.",
             samples_seen, words_checked, updates_seen);
    $display("Idle phases: none, sender 81%%, receiver 81%%, both 35%%.");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
